/* rtl/clcm_pkg.sv */
// ----------------------------------------------------------------------------
// Colour light channel mixer - shared types, constants and microcode
// Datapath widths, operand and opcode encodings, constant-divider tables and
// the control store that sequences the HSV and white-mix calculations.
// ----------------------------------------------------------------------------
package clcm_pkg;

    localparam int DP_W      = 19;   // widest intermediate: sat * 1524
    localparam int PC_W      = 6;
    localparam int REC_SHIFT = 20;
    localparam int REC_W     = 14;
    localparam int DIV_W     = 11;
    localparam int QE_W      = DP_W + REC_W - REC_SHIFT;

    localparam logic [15:0] MIRED_COOL = 16'd153;
    localparam logic [15:0] MIRED_WARM = 16'd500;

    localparam logic [7:0]  LEVEL_RESET = 8'd254;
    localparam logic [15:0] MIRED_RESET = 16'd370;

    typedef logic [DP_W-1:0] dp_t;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [2:0] {
        ATTR_ONOFF = 3'd0,
        ATTR_LEVEL = 3'd1,
        ATTR_HUE   = 3'd2,
        ATTR_SAT   = 3'd3,
        ATTR_TEMP  = 3'd4
    } attr_t;

    typedef enum logic [2:0] {
        DV_254,
        DV_255,
        DV_347,
        DV_1524,
        DV_100
    } div_code_t;

    typedef struct packed {
        logic      start;
        div_code_t code;
    } div_req_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL,
        OP_SUB,
        OP_ADD,
        OP_PASS,
        OP_DIV,
        OP_BR_OFF,
        OP_BR_TEMP,
        OP_BR_SZERO,
        OP_OUT_ZERO,
        OP_OUT_GREY,
        OP_OUT_HSV,
        OP_OUT_WHITE
    } op_t;

    typedef enum logic [4:0] {
        SRC_ZERO,
        SRC_LEVEL,
        SRC_HUE,
        SRC_SAT,
        SRC_MOFF,
        SRC_X0,
        SRC_X1,
        SRC_X2,
        SRC_X3,
        SRC_X4,
        SRC_X5,
        SRC_DQ,
        SRC_DR,
        SRC_K6,
        SRC_K80,
        SRC_K100,
        SRC_K170,
        SRC_K200,
        SRC_K220,
        SRC_K255,
        SRC_K1524
    } src_t;

    typedef enum logic [2:0] {
        DST_X0,
        DST_X1,
        DST_X2,
        DST_X3,
        DST_X4,
        DST_X5
    } dst_t;

    typedef struct packed {
        op_t       op;
        src_t      a;
        src_t      b;
        dst_t      dst;
        div_code_t dv;
        pc_t       target;
    } ucode_t;

    localparam pc_t L_GREY = 6'd25;
    localparam pc_t L_OFF  = 6'd26;
    localparam pc_t L_TEMP = 6'd27;

    // floor(2^REC_SHIFT / d); estimate is exact or one low for x < 2^REC_SHIFT
    function automatic logic [REC_W-1:0] div_recip(div_code_t c);
        logic [REC_W-1:0] r;
        case (c)
            DV_254:  r = 14'd4128;
            DV_255:  r = 14'd4112;
            DV_347:  r = 14'd3021;
            DV_1524: r = 14'd688;
            DV_100:  r = 14'd10485;
            default: r = 14'd4112;
        endcase
        return r;
    endfunction

    function automatic logic [DIV_W-1:0] div_const(div_code_t c);
        logic [DIV_W-1:0] d;
        case (c)
            DV_254:  d = 11'd254;
            DV_255:  d = 11'd255;
            DV_347:  d = 11'd347;
            DV_1524: d = 11'd1524;
            DV_100:  d = 11'd100;
            default: d = 11'd255;
        endcase
        return d;
    endfunction

    function automatic ucode_t uc_alu(op_t op, src_t a, src_t b, dst_t d);
        ucode_t w;
        w = '{op: op, a: a, b: b, dst: d, dv: DV_255, target: '0};
        return w;
    endfunction

    function automatic ucode_t uc_div(src_t a, div_code_t c);
        ucode_t w;
        w = '{op: OP_DIV, a: a, b: SRC_ZERO, dst: DST_X0, dv: c, target: '0};
        return w;
    endfunction

    function automatic ucode_t uc_br(op_t op, pc_t t);
        ucode_t w;
        w = '{op: op, a: SRC_ZERO, b: SRC_ZERO, dst: DST_X0, dv: DV_255, target: t};
        return w;
    endfunction

    function automatic ucode_t uc_ctl(op_t op);
        ucode_t w;
        w = '{op: op, a: SRC_ZERO, b: SRC_ZERO, dst: DST_X0, dv: DV_255, target: '0};
        return w;
    endfunction

    // Divider results are readable after the divider's product and result registers.
    function automatic ucode_t ucode_rom(pc_t pc);
        ucode_t w;
        case (pc)
            // dispatch
            6'd0:  w = uc_br(OP_BR_OFF, L_OFF);
            6'd1:  w = uc_br(OP_BR_TEMP, L_TEMP);
            6'd2:  w = uc_br(OP_BR_SZERO, L_GREY);
            // hue/saturation
            6'd3:  w = uc_alu(OP_MUL, SRC_HUE, SRC_K6, DST_X0);
            6'd4:  w = uc_div(SRC_X0, DV_254);
            6'd5:  w = uc_alu(OP_SUB, SRC_K255, SRC_SAT, DST_X1);
            6'd6:  w = uc_alu(OP_PASS, SRC_DQ, SRC_ZERO, DST_X3);      // sextant
            6'd7:  w = uc_alu(OP_MUL, SRC_DR, SRC_K6, DST_X2);         // rem
            6'd8:  w = uc_alu(OP_MUL, SRC_LEVEL, SRC_X1, DST_X4);
            6'd9:  w = uc_div(SRC_X4, DV_255);
            6'd10: w = uc_alu(OP_MUL, SRC_SAT, SRC_X2, DST_X0);
            6'd11: w = uc_alu(OP_PASS, SRC_DQ, SRC_ZERO, DST_X1);      // p
            6'd12: w = uc_div(SRC_X0, DV_1524);
            6'd13: w = uc_alu(OP_SUB, SRC_K1524, SRC_X2, DST_X0);
            6'd14: w = uc_alu(OP_SUB, SRC_K255, SRC_DQ, DST_X4);
            6'd15: w = uc_alu(OP_MUL, SRC_SAT, SRC_X0, DST_X0);
            6'd16: w = uc_div(SRC_X0, DV_1524);
            6'd17: w = uc_alu(OP_MUL, SRC_LEVEL, SRC_X4, DST_X4);
            6'd18: w = uc_alu(OP_SUB, SRC_K255, SRC_DQ, DST_X0);
            6'd19: w = uc_div(SRC_X4, DV_255);
            6'd20: w = uc_alu(OP_MUL, SRC_LEVEL, SRC_X0, DST_X0);
            6'd21: w = uc_alu(OP_PASS, SRC_DQ, SRC_ZERO, DST_X2);      // q
            6'd22: w = uc_div(SRC_X0, DV_255);
            6'd23: w = uc_ctl(OP_NOP);
            6'd24: w = uc_ctl(OP_OUT_HSV);                             // t from divider
            6'd25: w = uc_ctl(OP_OUT_GREY);
            6'd26: w = uc_ctl(OP_OUT_ZERO);
            // colour temperature
            6'd27: w = uc_alu(OP_MUL, SRC_MOFF, SRC_K100, DST_X0);
            6'd28: w = uc_div(SRC_X0, DV_347);
            6'd29: w = uc_ctl(OP_NOP);
            6'd30: w = uc_alu(OP_MUL, SRC_LEVEL, SRC_DQ, DST_X0);
            6'd31: w = uc_alu(OP_SUB, SRC_K100, SRC_DQ, DST_X1);
            6'd32: w = uc_div(SRC_X0, DV_100);
            6'd33: w = uc_alu(OP_MUL, SRC_LEVEL, SRC_X1, DST_X0);
            6'd34: w = uc_alu(OP_PASS, SRC_DQ, SRC_ZERO, DST_X2);      // warm
            6'd35: w = uc_div(SRC_X0, DV_100);
            6'd36: w = uc_ctl(OP_NOP);
            6'd37: w = uc_alu(OP_PASS, SRC_DQ, SRC_ZERO, DST_X3);      // cool
            6'd38: w = uc_alu(OP_MUL, SRC_X3, SRC_K200, DST_X0);
            6'd39: w = uc_alu(OP_MUL, SRC_X2, SRC_K255, DST_X1);
            6'd40: w = uc_alu(OP_ADD, SRC_X0, SRC_X1, DST_X0);
            6'd41: w = uc_div(SRC_X0, DV_255);
            6'd42: w = uc_alu(OP_MUL, SRC_X3, SRC_K220, DST_X0);
            6'd43: w = uc_alu(OP_PASS, SRC_DQ, SRC_ZERO, DST_X4);      // pixel red
            6'd44: w = uc_alu(OP_MUL, SRC_X2, SRC_K170, DST_X1);
            6'd45: w = uc_alu(OP_ADD, SRC_X0, SRC_X1, DST_X0);
            6'd46: w = uc_div(SRC_X0, DV_255);
            6'd47: w = uc_alu(OP_MUL, SRC_X3, SRC_K255, DST_X0);
            6'd48: w = uc_alu(OP_PASS, SRC_DQ, SRC_ZERO, DST_X1);      // pixel green
            6'd49: w = uc_alu(OP_MUL, SRC_X2, SRC_K80, DST_X5);
            6'd50: w = uc_alu(OP_ADD, SRC_X0, SRC_X5, DST_X0);
            6'd51: w = uc_div(SRC_X0, DV_255);
            6'd52: w = uc_ctl(OP_NOP);
            6'd53: w = uc_ctl(OP_OUT_WHITE);                           // pixel blue from divider
            default: w = uc_ctl(OP_OUT_ZERO);
        endcase
        return w;
    endfunction

endpackage

/* rtl/clcm_cdiv.sv */
// ----------------------------------------------------------------------------
// Colour light channel mixer - constant divider
// Divides by one of a few fixed constants: reciprocal multiply into a
// register, then back-multiply and a single correction into a result register.
// ----------------------------------------------------------------------------
module clcm_cdiv (
    input  logic               aclk,
    input  clcm_pkg::div_req_t req,
    input  clcm_pkg::dp_t      x,
    output clcm_pkg::dp_t      q,
    output clcm_pkg::dp_t      r
);

    localparam int PROD_W = clcm_pkg::DP_W + clcm_pkg::REC_W;
    localparam int BACK_W = clcm_pkg::QE_W + clcm_pkg::DIV_W;

    logic [PROD_W-1:0]             prod_reg;
    clcm_pkg::dp_t                 x_reg;
    clcm_pkg::div_code_t           code_reg;
    logic [clcm_pkg::QE_W-1:0]     q_est;
    logic [BACK_W-1:0]             back;
    clcm_pkg::dp_t                 rem_est;
    clcm_pkg::dp_t                 dval;
    logic [clcm_pkg::QE_W-1:0]     q_next;
    clcm_pkg::dp_t                 r_next;
    clcm_pkg::dp_t                 q_reg;
    clcm_pkg::dp_t                 r_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg    <= x;
            code_reg <= req.code;
            prod_reg <= PROD_W'(x) * PROD_W'(clcm_pkg::div_recip(req.code));
        end
    end

    always_comb begin
        q_est   = prod_reg[PROD_W-1:clcm_pkg::REC_SHIFT];
        dval    = clcm_pkg::DP_W'(clcm_pkg::div_const(code_reg));
        back    = BACK_W'(q_est) * BACK_W'(clcm_pkg::div_const(code_reg));
        rem_est = x_reg - back[clcm_pkg::DP_W-1:0];
        if (rem_est >= dval) begin
            q_next = q_est + clcm_pkg::QE_W'(1);
            r_next = rem_est - dval;
        end else begin
            q_next = q_est;
            r_next = rem_est;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= clcm_pkg::DP_W'(q_next);
        r_reg <= r_next;
    end

    assign q = q_reg;
    assign r = r_reg;

endmodule

/* rtl/color_light_channel_mixer_core.sv */
// The microcode sequence run from accept to result depends on the mode: off, zero
// saturation, hue/saturation or colour temperature.
// Transactions are not overlapped: a new one is taken the cycle after the sequencer
// hands over its result, since the multiplier and divider are shared.
// Foreign endpoints and unknown selectors are absorbed while idle, without starting the sequencer.
// Reset: light on, level 254, hue 0, saturation 0, 370 mireds, temperature mode.
// ----------------------------------------------------------------------------
// Colour light channel mixer core
// Stores light attributes and recomputes RGB and cool/warm white PWM duties
// plus an RGB pixel approximation using a microcoded datapath.
// ----------------------------------------------------------------------------
module color_light_channel_mixer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,   // light_endpoint
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [15:0] endpoint, [31:16] value
    input  logic [2:0]  s_tuser,     // [2:0] attribute
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata      // red, green, blue, cool, warm duty,
                                     // pixel red, green, blue (8 bits each)
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t               state_reg;
    clcm_pkg::pc_t        pc_reg;
    logic                 m_valid_reg;
    logic [15:0]          endpoint_reg;
    logic                 light_on_reg;
    logic [7:0]           level_reg;
    logic [7:0]           hue_reg;
    logic [7:0]           sat_reg;
    logic [15:0]          mired_reg;
    logic                 temp_sel_reg;

    clcm_pkg::dp_t        x0_reg, x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    logic [7:0]           red_reg, green_reg, blue_reg, cool_reg, warm_reg;
    logic [7:0]           pix_r_reg, pix_g_reg, pix_b_reg;

    clcm_pkg::ucode_t     uw;
    clcm_pkg::dp_t        a_val, b_val, alu_res, div_q, div_r;
    clcm_pkg::dp_t        moff;
    logic [2*clcm_pkg::DP_W-1:0] mul_full;
    clcm_pkg::div_req_t   div_req;
    logic [15:0]          s_endpoint;
    logic [15:0]          s_value;
    clcm_pkg::attr_t      s_attr;
    logic                 attr_ok;
    logic                 hit;
    logic                 run;
    logic                 out_op;
    logic                 out_fire;
    logic                 alu_wr;
    logic [7:0]           hsv_r, hsv_g, hsv_b;
    logic [7:0]           t_val;

    assign s_endpoint = s_tdata[15:0];
    assign s_value    = s_tdata[31:16];
    assign s_attr     = clcm_pkg::attr_t'(s_tuser);
    assign s_tready   = (state_reg == ST_IDLE);
    assign run        = (state_reg == ST_RUN);

    always_comb begin
        case (s_attr)
            clcm_pkg::ATTR_ONOFF,
            clcm_pkg::ATTR_LEVEL,
            clcm_pkg::ATTR_HUE,
            clcm_pkg::ATTR_SAT,
            clcm_pkg::ATTR_TEMP: attr_ok = 1'b1;
            default:             attr_ok = 1'b0;
        endcase
    end

    assign hit = s_tvalid && s_tready && attr_ok && (s_endpoint == endpoint_reg);

    assign uw = clcm_pkg::ucode_rom(pc_reg);

    always_comb begin
        if (mired_reg < clcm_pkg::MIRED_COOL) begin
            moff = '0;
        end else if (mired_reg > clcm_pkg::MIRED_WARM) begin
            moff = clcm_pkg::DP_W'(clcm_pkg::MIRED_WARM - clcm_pkg::MIRED_COOL);
        end else begin
            moff = clcm_pkg::DP_W'(mired_reg - clcm_pkg::MIRED_COOL);
        end
    end

    function automatic clcm_pkg::dp_t pick(clcm_pkg::src_t s);
        clcm_pkg::dp_t v;
        case (s)
            clcm_pkg::SRC_ZERO:  v = '0;
            clcm_pkg::SRC_LEVEL: v = clcm_pkg::DP_W'(level_reg);
            clcm_pkg::SRC_HUE:   v = clcm_pkg::DP_W'(hue_reg);
            clcm_pkg::SRC_SAT:   v = clcm_pkg::DP_W'(sat_reg);
            clcm_pkg::SRC_MOFF:  v = moff;
            clcm_pkg::SRC_X0:    v = x0_reg;
            clcm_pkg::SRC_X1:    v = x1_reg;
            clcm_pkg::SRC_X2:    v = x2_reg;
            clcm_pkg::SRC_X3:    v = x3_reg;
            clcm_pkg::SRC_X4:    v = x4_reg;
            clcm_pkg::SRC_X5:    v = x5_reg;
            clcm_pkg::SRC_DQ:    v = div_q;
            clcm_pkg::SRC_DR:    v = div_r;
            clcm_pkg::SRC_K6:    v = clcm_pkg::DP_W'(6);
            clcm_pkg::SRC_K80:   v = clcm_pkg::DP_W'(80);
            clcm_pkg::SRC_K100:  v = clcm_pkg::DP_W'(100);
            clcm_pkg::SRC_K170:  v = clcm_pkg::DP_W'(170);
            clcm_pkg::SRC_K200:  v = clcm_pkg::DP_W'(200);
            clcm_pkg::SRC_K220:  v = clcm_pkg::DP_W'(220);
            clcm_pkg::SRC_K255:  v = clcm_pkg::DP_W'(255);
            clcm_pkg::SRC_K1524: v = clcm_pkg::DP_W'(1524);
            default:             v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        a_val    = pick(uw.a);
        b_val    = pick(uw.b);
        mul_full = {{clcm_pkg::DP_W{1'b0}}, a_val} * {{clcm_pkg::DP_W{1'b0}}, b_val};
        alu_wr   = 1'b0;
        out_op   = 1'b0;
        case (uw.op)
            clcm_pkg::OP_MUL: begin
                alu_res = mul_full[clcm_pkg::DP_W-1:0];
                alu_wr  = 1'b1;
            end
            clcm_pkg::OP_SUB: begin
                alu_res = a_val - b_val;
                alu_wr  = 1'b1;
            end
            clcm_pkg::OP_ADD: begin
                alu_res = a_val + b_val;
                alu_wr  = 1'b1;
            end
            clcm_pkg::OP_PASS: begin
                alu_res = a_val;
                alu_wr  = 1'b1;
            end
            clcm_pkg::OP_OUT_ZERO,
            clcm_pkg::OP_OUT_GREY,
            clcm_pkg::OP_OUT_HSV,
            clcm_pkg::OP_OUT_WHITE: begin
                alu_res = a_val;
                out_op  = 1'b1;
            end
            default: begin
                alu_res = a_val;
            end
        endcase
    end

    assign div_req.start = run && (uw.op == clcm_pkg::OP_DIV);
    assign div_req.code  = uw.dv;
    assign out_fire      = run && out_op && (!m_valid_reg || m_tready);

    clcm_cdiv u_cdiv (
        .aclk (aclk),
        .req  (div_req),
        .x    (a_val),
        .q    (div_q),
        .r    (div_r)
    );

    // sextant 6 (hue 254 or 255) falls into the last arm
    assign t_val = div_q[7:0];
    always_comb begin
        case (x3_reg[2:0])
            3'd0:    begin hsv_r = level_reg;   hsv_g = t_val;       hsv_b = x1_reg[7:0]; end
            3'd1:    begin hsv_r = x2_reg[7:0]; hsv_g = level_reg;   hsv_b = x1_reg[7:0]; end
            3'd2:    begin hsv_r = x1_reg[7:0]; hsv_g = level_reg;   hsv_b = t_val;       end
            3'd3:    begin hsv_r = x1_reg[7:0]; hsv_g = x2_reg[7:0]; hsv_b = level_reg;   end
            3'd4:    begin hsv_r = t_val;       hsv_g = x1_reg[7:0]; hsv_b = level_reg;   end
            default: begin hsv_r = level_reg;   hsv_g = x1_reg[7:0]; hsv_b = x2_reg[7:0]; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pc_reg       <= '0;
            m_valid_reg  <= 1'b0;
            endpoint_reg <= '0;
            light_on_reg <= 1'b1;
            level_reg    <= clcm_pkg::LEVEL_RESET;
            hue_reg      <= '0;
            sat_reg      <= '0;
            mired_reg    <= clcm_pkg::MIRED_RESET;
            temp_sel_reg <= 1'b1;
        end else begin
            if (cfg_we) begin
                endpoint_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_tready && !out_fire) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (hit) begin
                        case (s_attr)
                            clcm_pkg::ATTR_ONOFF: light_on_reg <= s_value[0];
                            clcm_pkg::ATTR_LEVEL: level_reg <= s_value[7:0];
                            clcm_pkg::ATTR_HUE: begin
                                hue_reg      <= s_value[7:0];
                                temp_sel_reg <= 1'b0;
                            end
                            clcm_pkg::ATTR_SAT: begin
                                sat_reg      <= s_value[7:0];
                                temp_sel_reg <= 1'b0;
                            end
                            clcm_pkg::ATTR_TEMP: begin
                                mired_reg    <= s_value;
                                temp_sel_reg <= 1'b1;
                            end
                            default: ;
                        endcase
                        pc_reg    <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    case (uw.op)
                        clcm_pkg::OP_BR_OFF:
                            pc_reg <= !light_on_reg ? uw.target : pc_reg + clcm_pkg::PC_W'(1);
                        clcm_pkg::OP_BR_TEMP:
                            pc_reg <= temp_sel_reg ? uw.target : pc_reg + clcm_pkg::PC_W'(1);
                        clcm_pkg::OP_BR_SZERO:
                            pc_reg <= (sat_reg == 8'd0) ? uw.target
                                                        : pc_reg + clcm_pkg::PC_W'(1);
                        clcm_pkg::OP_OUT_ZERO,
                        clcm_pkg::OP_OUT_GREY,
                        clcm_pkg::OP_OUT_HSV,
                        clcm_pkg::OP_OUT_WHITE: begin
                            if (out_fire) begin
                                m_valid_reg <= 1'b1;
                                state_reg   <= ST_IDLE;
                            end
                        end
                        default: pc_reg <= pc_reg + clcm_pkg::PC_W'(1);
                    endcase
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (run && alu_wr) begin
            case (uw.dst)
                clcm_pkg::DST_X0: x0_reg <= alu_res;
                clcm_pkg::DST_X1: x1_reg <= alu_res;
                clcm_pkg::DST_X2: x2_reg <= alu_res;
                clcm_pkg::DST_X3: x3_reg <= alu_res;
                clcm_pkg::DST_X4: x4_reg <= alu_res;
                clcm_pkg::DST_X5: x5_reg <= alu_res;
                default: ;
            endcase
        end
        if (out_fire) begin
            case (uw.op)
                clcm_pkg::OP_OUT_GREY: begin
                    red_reg   <= level_reg;
                    green_reg <= level_reg;
                    blue_reg  <= level_reg;
                    cool_reg  <= '0;
                    warm_reg  <= '0;
                    pix_r_reg <= level_reg;
                    pix_g_reg <= level_reg;
                    pix_b_reg <= level_reg;
                end
                clcm_pkg::OP_OUT_HSV: begin
                    red_reg   <= hsv_r;
                    green_reg <= hsv_g;
                    blue_reg  <= hsv_b;
                    cool_reg  <= '0;
                    warm_reg  <= '0;
                    pix_r_reg <= hsv_r;
                    pix_g_reg <= hsv_g;
                    pix_b_reg <= hsv_b;
                end
                clcm_pkg::OP_OUT_WHITE: begin
                    red_reg   <= '0;
                    green_reg <= '0;
                    blue_reg  <= '0;
                    cool_reg  <= x3_reg[7:0];
                    warm_reg  <= x2_reg[7:0];
                    pix_r_reg <= x4_reg[7:0];
                    pix_g_reg <= x1_reg[7:0];
                    pix_b_reg <= div_q[7:0];
                end
                default: begin
                    red_reg   <= '0;
                    green_reg <= '0;
                    blue_reg  <= '0;
                    cool_reg  <= '0;
                    warm_reg  <= '0;
                    pix_r_reg <= '0;
                    pix_g_reg <= '0;
                    pix_b_reg <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {pix_b_reg, pix_g_reg, pix_r_reg, warm_reg,
                       cool_reg, blue_reg, green_reg, red_reg};

endmodule

/* rtl/clcm_checker.sv */
// ----------------------------------------------------------------------------
// Colour light channel mixer - port checker
// Watches the top level's stream ports for reset, stall, ordering and mode-exclusivity slips.
// ----------------------------------------------------------------------------
module clcm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_rise_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while input side idle");

    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result one cycle after transaction");

    a_mode_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:0] == 24'd0 || m_tdata[39:24] == 16'd0))
        else $error("RGB and white duties both active");

endmodule

bind color_light_channel_mixer_core clcm_checker u_clcm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
